/* sv/pidal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pidal_pkg;

  // register and field widths
  localparam int SP_W       = 11;
  localparam int GAIN_W     = 32;
  localparam int ELIM_W     = 11;
  localparam int ILIM_W     = 20;
  localparam int ALPHA_W    = 17;
  localparam int LOSTLIM_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int ERR_W   = 12;
  localparam int SUM_W   = 22;
  localparam int SLOPE_W = 31;
  localparam int DIFF_W  = 32;
  localparam int DRIVE_W = 32;
  localparam int MISS_W  = 8;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 52;
  localparam int STEP_W  = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_KP         = 3'd1,
    CFG_KI         = 3'd2,
    CFG_KD         = 3'd3,
    CFG_ERR_LIMIT  = 3'd4,
    CFG_INT_LIMIT  = 3'd5,
    CFG_ALPHA      = 3'd6,
    CFG_LOST_LIMIT = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [SP_W-1:0]      setpoint;
    logic [GAIN_W-1:0]    kp;
    logic [GAIN_W-1:0]    ki;
    logic [GAIN_W-1:0]    kd;
    logic [ELIM_W-1:0]    err_cap;
    logic [ILIM_W-1:0]    int_limit;
    logic [ALPHA_W-1:0]   alpha;
    logic [LOSTLIM_W-1:0] lost_limit;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ALPHA_DIFF,
    MUL_KP_ERR,
    MUL_KI_SUM,
    MUL_KD_SLOPE
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD4,
    ACC_ADD4,
    ACC_ADD20
  } acc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP_IF_ZERO,
    SEQ_END
  } seq_op_t;

  typedef logic [STEP_W-1:0] step_t;

  // one microcode word
  typedef struct packed {
    logic     err_ld;
    logic     sum_ld;
    logic     filt_ld;
    logic     drive_ld;
    logic     emit;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    seq_op_t  seq_op;
    step_t    target;
  } ctrl_word_t;

  localparam ctrl_word_t CTRL_NOP = '{
    err_ld:   1'b0,
    sum_ld:   1'b0,
    filt_ld:  1'b0,
    drive_ld: 1'b0,
    emit:     1'b0,
    mul_sel:  MUL_NONE,
    acc_op:   ACC_HOLD,
    seq_op:   SEQ_NEXT,
    target:   '0
  };

endpackage

`default_nettype wire

/* sv/pidal_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidal_cfg_regs import pidal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= SP_W'(320);
      cfg.kp         <= GAIN_W'(174483);
      cfg.ki         <= GAIN_W'(6174);
      cfg.kd         <= GAIN_W'(805306);
      cfg.err_cap    <= ELIM_W'(160);
      cfg.int_limit  <= ILIM_W'(60000);
      cfg.alpha      <= ALPHA_W'(6554);
      cfg.lost_limit <= LOSTLIM_W'(200);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SETPOINT:   cfg.setpoint   <= cfg_data[SP_W-1:0];
        CFG_KP:         cfg.kp         <= cfg_data[GAIN_W-1:0];
        CFG_KI:         cfg.ki         <= cfg_data[GAIN_W-1:0];
        CFG_KD:         cfg.kd         <= cfg_data[GAIN_W-1:0];
        CFG_ERR_LIMIT:  cfg.err_cap    <= cfg_data[ELIM_W-1:0];
        CFG_INT_LIMIT:  cfg.int_limit  <= cfg_data[ILIM_W-1:0];
        CFG_ALPHA:      cfg.alpha      <= cfg_data[ALPHA_W-1:0];
        CFG_LOST_LIMIT: cfg.lost_limit <= cfg_data[LOSTLIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/pidal_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidal_sequencer import pidal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       in_accept,
  input  logic       err_zero,
  input  logic       out_free,
  output ctrl_word_t cw
);

  localparam step_t STEP_ERR       = 4'd0;
  localparam step_t STEP_SUM       = 4'd1;
  localparam step_t STEP_MUL_ALPHA = 4'd2;
  localparam step_t STEP_FILTER    = 4'd3;
  localparam step_t STEP_TERM_P    = 4'd4;
  localparam step_t STEP_TERM_I    = 4'd5;
  localparam step_t STEP_TERM_D    = 4'd6;
  localparam step_t STEP_DRIVE     = 4'd7;
  localparam step_t STEP_EMIT      = 4'd8;

  logic  busy;
  step_t step;

  // microprogram rom
  function automatic ctrl_word_t rom_word(input step_t s);
    ctrl_word_t w;
    w = CTRL_NOP;
    unique case (s)
      STEP_ERR: begin
        w.err_ld = 1'b1;
        w.seq_op = SEQ_JUMP_IF_ZERO;
        w.target = STEP_EMIT;
      end
      STEP_SUM: begin
        w.sum_ld = 1'b1;
      end
      STEP_MUL_ALPHA: begin
        w.mul_sel = MUL_ALPHA_DIFF;
      end
      STEP_FILTER: begin
        w.filt_ld = 1'b1;
        w.mul_sel = MUL_KP_ERR;
      end
      STEP_TERM_P: begin
        w.acc_op  = ACC_LOAD4;
        w.mul_sel = MUL_KI_SUM;
      end
      STEP_TERM_I: begin
        w.acc_op  = ACC_ADD4;
        w.mul_sel = MUL_KD_SLOPE;
      end
      STEP_TERM_D: begin
        w.acc_op = ACC_ADD20;
      end
      STEP_DRIVE: begin
        w.drive_ld = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.seq_op = SEQ_END;
      end
      default: begin
        w.emit   = 1'b1;
        w.seq_op = SEQ_END;
      end
    endcase
    return w;
  endfunction

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  always_comb begin
    cw = busy ? rom_word(step) : CTRL_NOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_ERR;
    end else if (in_accept) begin
      busy <= 1'b1;
      step <= STEP_ERR;
    end else if (busy) begin
      unique case (cw.seq_op)
        SEQ_NEXT:         step <= step + STEP_W'(1);
        SEQ_JUMP_IF_ZERO: step <= err_zero ? cw.target : step + STEP_W'(1);
        SEQ_END: begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end
        default: step <= STEP_ERR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> busy && step == STEP_ERR)
    else $error("accepted item did not start the program");

  a_zero_skips: assert property (@(posedge clk) disable iff (rst)
    busy && cw.seq_op == SEQ_JUMP_IF_ZERO && err_zero |=> busy && step == STEP_EMIT)
    else $error("zero error did not branch to the emit step");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    busy && cw.seq_op == SEQ_END && out_free |=> !busy && !in_stall)
    else $error("sequencer stayed busy after handing off its result");
`endif

endmodule

`default_nettype wire

/* sv/pidal_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidal_datapath import pidal_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_regs_t                 cfg,
  input  logic                      in_accept,
  input  logic [COORD_BITS-1:0]     measured_position,
  input  ctrl_word_t                cw,
  output logic                      err_zero,
  output logic                      out_free,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [DRIVE_W-1:0] drive,
  output logic                      target_lost,
  output logic                      drive_updated
);

  localparam int WIDE_W = (COORD_BITS > SP_W) ? COORD_BITS : SP_W;
  localparam int RAW_W  = WIDE_W + 1;

  localparam logic signed [PROD_W-1:0]    HALF4  = PROD_W'(8);
  localparam logic signed [PROD_W-1:0]    HALF16 = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0]    HALF20 = PROD_W'(524288);
  localparam logic signed [SLOPE_W+2:0]   SLOPE_MAX = (SLOPE_W+3)'(30'h3FFF_FFFF);
  localparam logic signed [SLOPE_W+2:0]   SLOPE_MIN = -SLOPE_MAX;
  localparam logic signed [ACC_W-1:0]     DRV_MAX = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]     DRV_MIN = -DRV_MAX - ACC_W'(1);

  // item and controller state
  logic [COORD_BITS-1:0]     meas;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DRIVE_W-1:0] held_drive;
  logic [MISS_W-1:0]         miss_count;
  logic                      lost_flag;
  logic                      updated;

  logic signed [RAW_W-1:0]     raw_err;
  logic signed [RAW_W-1:0]     elim_pos;
  logic signed [RAW_W-1:0]     elim_neg;
  logic signed [RAW_W-1:0]     err_clamp;
  logic signed [ERR_W-1:0]     err_next;
  logic [MISS_W-1:0]           miss_inc;
  logic [MISS_W-1:0]           miss_next;
  logic                        lost_next;
  logic signed [SUM_W:0]       sum_ext;
  logic signed [SUM_W:0]       ilim_pos;
  logic signed [SUM_W-1:0]     sum_next;
  logic signed [ERR_W:0]       err_delta;
  logic signed [ERR_W+16:0]    raw_slope;
  logic signed [DIFF_W-1:0]    diff_next;
  logic [ALPHA_W-1:0]          alpha_eff;
  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [2*MUL_W-1:0]   mul_full;
  logic signed [PROD_W-1:0]    prod_r16;
  logic signed [SLOPE_W+2:0]   slope_sum;
  logic signed [SLOPE_W-1:0]   slope_next;
  logic signed [PROD_W-1:0]    term_full;
  logic signed [ACC_W-1:0]     acc_base;
  logic signed [ACC_W-1:0]     acc_next;
  logic signed [DRIVE_W-1:0]   drive_next;
  logic                        out_load;

  // error against setpoint and clamp
  always_comb begin
    raw_err  = $signed({1'b0, WIDE_W'(cfg.setpoint)}) - $signed({1'b0, WIDE_W'(meas)});
    elim_pos = $signed(RAW_W'(cfg.err_cap));
    elim_neg = -elim_pos;
    err_zero = (raw_err == '0);
    if (raw_err > elim_pos) begin
      err_clamp = elim_pos;
    end else if (raw_err < elim_neg) begin
      err_clamp = elim_neg;
    end else begin
      err_clamp = raw_err;
    end
    err_next = ERR_W'(err_clamp);
  end

  // saturating miss counter
  always_comb begin
    miss_inc = (miss_count != '1) ? miss_count + MISS_W'(1) : miss_count;
    if (miss_inc >= cfg.lost_limit) begin
      miss_next = cfg.lost_limit;
      lost_next = 1'b1;
    end else begin
      miss_next = miss_inc;
      lost_next = lost_flag;
    end
  end

  // integral and raw filter input
  always_comb begin
    sum_ext  = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    ilim_pos = $signed((SUM_W+1)'(cfg.int_limit));
    if (sum_ext > ilim_pos) begin
      sum_next = SUM_W'(ilim_pos);
    end else if (sum_ext < -ilim_pos) begin
      sum_next = SUM_W'(-ilim_pos);
    end else begin
      sum_next = SUM_W'(sum_ext);
    end
    err_delta = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);
    raw_slope = {err_delta, 16'd0};
    diff_next = DIFF_W'(raw_slope) - DIFF_W'(slope);
  end

  // shared multiplier operand select
  always_comb begin
    alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    unique case (cw.mul_sel)
      MUL_ALPHA_DIFF: begin
        mul_a = MUL_W'(alpha_eff);
        mul_b = MUL_W'(diff);
      end
      MUL_KP_ERR: begin
        mul_a = MUL_W'(cfg.kp);
        mul_b = MUL_W'(err);
      end
      MUL_KI_SUM: begin
        mul_a = MUL_W'(cfg.ki);
        mul_b = MUL_W'(error_sum);
      end
      MUL_KD_SLOPE: begin
        mul_a = MUL_W'(cfg.kd);
        mul_b = MUL_W'(slope);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // filter update, round to nearest with ties up
  always_comb begin
    prod_r16  = (prod + HALF16) >>> 16;
    slope_sum = (SLOPE_W+3)'(slope) + (SLOPE_W+3)'(prod_r16);
    if (slope_sum > SLOPE_MAX) begin
      slope_next = SLOPE_W'(SLOPE_MAX);
    end else if (slope_sum < SLOPE_MIN) begin
      slope_next = SLOPE_W'(SLOPE_MIN);
    end else begin
      slope_next = SLOPE_W'(slope_sum);
    end
  end

  // term accumulation and drive saturation
  always_comb begin
    if (cw.acc_op == ACC_ADD20) begin
      term_full = (prod + HALF20) >>> 20;
    end else begin
      term_full = (prod + HALF4) >>> 4;
    end
    acc_base = (cw.acc_op == ACC_LOAD4) ? '0 : acc;
    acc_next = acc_base + ACC_W'(term_full);
    if (acc > DRV_MAX) begin
      drive_next = DRIVE_W'(DRV_MAX);
    end else if (acc < DRV_MIN) begin
      drive_next = DRIVE_W'(DRV_MIN);
    end else begin
      drive_next = DRIVE_W'(acc);
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign out_load = cw.emit && out_free;

  // scratch registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      meas <= measured_position;
    end
    if (cw.err_ld) begin
      err <= err_next;
    end
    if (cw.sum_ld) begin
      diff <= diff_next;
    end
    if (cw.mul_sel != MUL_NONE) begin
      prod <= PROD_W'(mul_full);
    end
    if (cw.acc_op != ACC_HOLD) begin
      acc <= acc_next;
    end
    if (out_load) begin
      drive         <= held_drive;
      target_lost   <= lost_flag;
      drive_updated <= updated;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_count <= '0;
      lost_flag  <= 1'b0;
      updated    <= 1'b0;
      error_sum  <= '0;
      slope      <= '0;
      prev_err   <= '0;
      held_drive <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cw.err_ld) begin
        if (err_zero) begin
          miss_count <= miss_next;
          lost_flag  <= lost_next;
          updated    <= 1'b0;
        end else begin
          miss_count <= '0;
          lost_flag  <= 1'b0;
          updated    <= 1'b1;
        end
      end
      if (cw.sum_ld) begin
        error_sum <= sum_next;
      end
      if (cw.filt_ld) begin
        slope    <= slope_next;
        prev_err <= err;
      end
      if (cw.drive_ld) begin
        held_drive <= drive_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/pid_axis_with_lost_detect_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// in       | sink      | in_valid / in_stall    | measured_position
// out      | source    | out_valid / out_stall  | drive, target_lost, drive_updated
// cfg      | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// after its accept, an item that recomputes the drive runs nine microcode steps,
//   a sequence set by the single 33x33 multiplier that serves the filter and
//   the three gain terms one after another
// an item with zero error runs the error step and then jumps to the emit step
// rst is synchronous: clears controller state, loads register defaults
// a finished result sits in the output register; while it is stalled the emit step
//   waits, so at most one further item is in flight behind it

module pid_axis_with_lost_detect_top import pidal_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                      clk,
  input  logic                      rst,

  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_BITS-1:0]     measured_position,

  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] drive,
  output logic                      target_lost,
  output logic                      drive_updated,

  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_regs_t  cfg;
  ctrl_word_t cw;
  logic       in_accept;
  logic       err_zero;
  logic       out_free;

  // gains, limits, setpoint
  pidal_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // step counter and microcode rom; branches on zero error
  pidal_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_accept (in_accept),
    .err_zero  (err_zero),
    .out_free  (out_free),
    .cw        (cw)
  );

  // error, integral, filter, shared multiplier, accumulator, output register
  pidal_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_accept         (in_accept),
    .measured_position (measured_position),
    .cw                (cw),
    .err_zero          (err_zero),
    .out_free          (out_free),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .drive             (drive),
    .target_lost       (target_lost),
    .drive_updated     (drive_updated)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pidal_pkg::*;

  localparam int COORD_BITS    = 11;
  localparam int PHASE_ITEMS   = 60;   // random items per register setting
  localparam int LONG_MISS_RUN = 258;  // long enough to pin the miss counter at 255
  localparam int SETTLE_CYCLES = 12;

  localparam longint SLOPE_BOUND = (longint'(1) << 30) - 1;
  localparam longint DRIVE_HI    = 64'sd2147483647;
  localparam longint DRIVE_LO    = -64'sd2147483648;
  localparam longint ALPHA_UNITY = 64'sd65536;

  // one result item as the block reports it
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      lost;
    logic                      updated;
  } axis_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one line of the directed table: either a position item or a register write
  typedef struct packed {
    row_kind_t          kind;
    cfg_index_t         idx;
    logic [31:0]        val;
    logic               typed;   // expectation typed in below, not predicted
    axis_result_t       want;
  } stim_row_t;

  // clock, reset and block ports
  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [COORD_BITS-1:0]     measured_position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic                      target_lost;
  logic                      drive_updated;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // idle percentages per side, changed between phases
  int tx_idle_pct = 21;
  int rx_idle_pct = 85;

  // controller copy kept by the testbench
  cfg_regs_t                 regs_model;
  logic [MISS_W-1:0]         miss_cnt;
  logic                      lost_st;
  logic signed [SUM_W-1:0]   sum_st;
  logic signed [31:0]        slope_st;
  logic signed [ERR_W-1:0]   prev_err_st;
  logic signed [DRIVE_W-1:0] held_drive_st;

  // results still owed by the block, oldest first
  axis_result_t pending_results[$];
  axis_result_t oldest;
  logic         items_pending = 1'b0;

  // bookkeeping
  int n_fail    = 0;
  int n_items   = 0;
  int n_writes  = 0;
  int n_checked = 0;
  int n_updates = 0;
  int n_lost    = 0;
  int n_sat     = 0;

  pid_axis_with_lost_detect_top #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .measured_position(measured_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive(drive),
    .target_lost(target_lost),
    .drive_updated(drive_updated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest legal run with both sides idling hard
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // round to nearest, ties toward plus infinity
  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // advances the controller copy by one measurement, returns the result item
  function automatic axis_result_t pid_predict(logic [COORD_BITS-1:0] pos);
    axis_result_t res;
    longint sp, meas, err, elim, ilim, alpha, gp, gi, gd;
    longint sum, slope, prev, diff, total;
    sp   = regs_model.setpoint;
    meas = pos;
    err  = sp - meas;
    res.updated = 1'b0;
    if (err == 0) begin
      // a miss: count it, everything else holds
      if (miss_cnt != 8'hFF)
        miss_cnt = miss_cnt + 1'b1;
      if (miss_cnt >= regs_model.lost_limit) begin
        lost_st  = 1'b1;
        miss_cnt = regs_model.lost_limit;
      end
    end else begin
      elim  = regs_model.err_cap;
      ilim  = regs_model.int_limit;
      alpha = regs_model.alpha;
      if (alpha > ALPHA_UNITY)
        alpha = ALPHA_UNITY;
      gp    = regs_model.kp;
      gi    = regs_model.ki;
      gd    = regs_model.kd;
      sum   = sum_st;
      slope = slope_st;
      prev  = prev_err_st;
      miss_cnt = '0;
      lost_st  = 1'b0;
      err   = clip(err, -elim, elim);
      sum   = clip(sum + err, -ilim, ilim);
      // low-pass on the error step, Q15.16
      diff  = (err - prev) * 65536 - slope;
      slope = clip(slope + rnd_shr(alpha * diff, 16), -SLOPE_BOUND, SLOPE_BOUND);
      total = rnd_shr(gp * err, 4) + rnd_shr(gi * sum, 4) + rnd_shr(gd * slope, 20);
      held_drive_st = DRIVE_W'(clip(total, DRIVE_LO, DRIVE_HI));
      sum_st      = sum[SUM_W-1:0];
      slope_st    = slope[31:0];
      prev_err_st = err[ERR_W-1:0];
      res.updated = 1'b1;
    end
    res.drive = held_drive_st;
    res.lost  = lost_st;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    n_fail++;
    $display("[%0t] mismatch %0d, %s: got %0d, expected %0d", $time, n_fail, what, got, want);
  endtask

  // every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, drive", drive, 0);
      end else begin
        oldest = pending_results.pop_front();
        n_checked++;
        if (drive !== oldest.drive)
          report_mismatch("drive", drive, oldest.drive);
        if (target_lost !== oldest.lost)
          report_mismatch("target_lost", target_lost, oldest.lost);
        if (drive_updated !== oldest.updated)
          report_mismatch("drive_updated", drive_updated, oldest.updated);
      end
      if (drive_updated)
        n_updates++;
      if (target_lost)
        n_lost++;
      if (drive == DRIVE_HI || drive == DRIVE_LO)
        n_sat++;
    end
  end

  // receiver stalls at random, changed only at the falling edge
  always @(negedge clk)
    out_stall = !rst && ($urandom_range(0, 99) < rx_idle_pct);

  // ---------------------------------------------------------------------------
  // drivers, entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    items_pending = 1'b0;
  endtask

  // valid stays high into the next item unless a gap is drawn
  task automatic send_item(logic [COORD_BITS-1:0] pos, logic typed, axis_result_t want);
    axis_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    measured_position = pos;
    do @(posedge clk); while (in_stall);
    predicted = pid_predict(pos);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
    items_pending = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_pos(logic [COORD_BITS-1:0] pos);
    send_item(pos, 1'b0, '0);
  endtask

  // register writes only with the block idle
  task automatic cfg_write(cfg_index_t idx, logic [31:0] val);
    if (items_pending)
      settle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SETPOINT:   regs_model.setpoint   = val[SP_W-1:0];
      CFG_KP:         regs_model.kp         = val;
      CFG_KI:         regs_model.ki         = val;
      CFG_KD:         regs_model.kd         = val;
      CFG_ERR_LIMIT:  regs_model.err_cap    = val[ELIM_W-1:0];
      CFG_INT_LIMIT:  regs_model.int_limit  = val[ILIM_W-1:0];
      CFG_ALPHA:      regs_model.alpha      = val[ALPHA_W-1:0];
      CFG_LOST_LIMIT: regs_model.lost_limit = val[LOSTLIM_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // gains: zero, full scale, near the defaults, or anything
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 4_000_000);
      4:       return $urandom_range(0, 32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  // a fresh setting of all eight registers
  task automatic load_random_regs(logic long_lost);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 2047;
      default: v = $urandom_range(0, 2047);
    endcase
    cfg_write(CFG_SETPOINT, v);
    cfg_write(CFG_KP, pick_gain());
    cfg_write(CFG_KI, pick_gain());
    cfg_write(CFG_KD, pick_gain());
    case ($urandom_range(0, 4))
      0:       v = 0;
      1:       v = 2047;
      2:       v = $urandom_range(0, 2047);
      default: v = $urandom_range(1, 400);
    endcase
    cfg_write(CFG_ERR_LIMIT, v);
    case ($urandom_range(0, 4))
      0:       v = 0;
      1:       v = 20'hFFFFF;
      2:       v = $urandom_range(0, 20'hFFFFF);
      default: v = $urandom_range(0, 5000);
    endcase
    cfg_write(CFG_INT_LIMIT, v);
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = ALPHA_ONE;
      2:       v = 17'h1FFFF;
      3:       v = $urandom_range(32'h10001, 32'h1FFFF);
      default: v = $urandom_range(0, ALPHA_ONE);
    endcase
    cfg_write(CFG_ALPHA, v);
    if (long_lost)
      v = 255;
    else if ($urandom_range(0, 3) == 0)
      v = $urandom_range(0, 255);
    else
      v = $urandom_range(0, 8);
    cfg_write(CFG_LOST_LIMIT, v);
  endtask

  // directed table rows
  function automatic stim_row_t pos_row(int pos);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.val   = pos;
    return r;
  endfunction

  function automatic stim_row_t pos_row_exp(int pos, longint drv, logic lost, logic upd);
    stim_row_t r;
    r              = pos_row(pos);
    r.typed        = 1'b1;
    r.want.drive   = drv[DRIVE_W-1:0];
    r.want.lost    = lost;
    r.want.updated = upd;
    return r;
  endfunction

  function automatic stim_row_t reg_row(cfg_index_t idx, logic [31:0] val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t dir_rows[$];
    int        ph;
    int        made;
    int        run;
    int        pick;
    int        pos_i;

    // register defaults and cleared state, as after reset
    regs_model.setpoint   = 320;
    regs_model.kp         = 174483;
    regs_model.ki         = 6174;
    regs_model.kd         = 805306;
    regs_model.err_cap    = 160;
    regs_model.int_limit  = 60000;
    regs_model.alpha      = 6554;
    regs_model.lost_limit = 200;
    miss_cnt      = '0;
    lost_st       = 1'b0;
    sum_st        = '0;
    slope_st      = '0;
    prev_err_st   = '0;
    held_drive_st = '0;

    // directed table
    dir_rows.push_back(pos_row_exp(320, 0, 1'b0, 1'b0));  // on setpoint right after reset
    dir_rows.push_back(pos_row(0));                        // error clamps at +limit
    dir_rows.push_back(pos_row(2047));                     // error clamps at -limit
    dir_rows.push_back(pos_row(319));
    dir_rows.push_back(pos_row(321));
    dir_rows.push_back(reg_row(CFG_ALPHA, 32'h1FFFF));     // alpha above one acts as one
    dir_rows.push_back(pos_row(400));
    dir_rows.push_back(pos_row(250));
    dir_rows.push_back(reg_row(CFG_ALPHA, 0));             // derivative frozen
    dir_rows.push_back(pos_row(1000));
    dir_rows.push_back(reg_row(CFG_KP, 0));
    dir_rows.push_back(reg_row(CFG_KI, 0));
    dir_rows.push_back(reg_row(CFG_KD, 0));
    dir_rows.push_back(pos_row_exp(5, 0, 1'b0, 1'b1));    // zero gains give zero drive
    dir_rows.push_back(reg_row(CFG_LOST_LIMIT, 0));        // first miss flags lost
    dir_rows.push_back(pos_row_exp(320, 0, 1'b1, 1'b0));
    dir_rows.push_back(pos_row_exp(321, 0, 1'b0, 1'b1));  // a hit clears the flag
    dir_rows.push_back(reg_row(CFG_LOST_LIMIT, 1));
    dir_rows.push_back(pos_row_exp(320, 0, 1'b1, 1'b0));
    dir_rows.push_back(pos_row_exp(0, 0, 1'b0, 1'b1));
    dir_rows.push_back(reg_row(CFG_LOST_LIMIT, 3));
    dir_rows.push_back(pos_row_exp(320, 0, 1'b0, 1'b0));
    dir_rows.push_back(pos_row_exp(320, 0, 1'b0, 1'b0));
    dir_rows.push_back(pos_row_exp(320, 0, 1'b1, 1'b0));  // third miss reaches the limit
    dir_rows.push_back(reg_row(CFG_ERR_LIMIT, 0));         // hits with error forced to zero
    dir_rows.push_back(reg_row(CFG_KP, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(CFG_KI, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(CFG_KD, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(CFG_ALPHA, ALPHA_ONE));
    dir_rows.push_back(pos_row(0));
    dir_rows.push_back(pos_row(2047));
    dir_rows.push_back(reg_row(CFG_ERR_LIMIT, 2047));      // full-range error, big integral
    dir_rows.push_back(reg_row(CFG_SETPOINT, 2047));
    dir_rows.push_back(reg_row(CFG_INT_LIMIT, 32'hFFFFF));
    dir_rows.push_back(pos_row(0));
    dir_rows.push_back(pos_row(0));
    dir_rows.push_back(reg_row(CFG_SETPOINT, 0));          // swing to the negative rail
    dir_rows.push_back(pos_row(2047));
    dir_rows.push_back(pos_row(2047));
    dir_rows.push_back(pos_row(1));
    dir_rows.push_back(reg_row(CFG_INT_LIMIT, 0));         // integral pinned at zero
    dir_rows.push_back(pos_row(1024));
    dir_rows.push_back(reg_row(CFG_SETPOINT, 2047));
    dir_rows.push_back(pos_row(2047));

    // synchronous reset, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, sender light and receiver heavy idling
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      else
        send_item(dir_rows[i].val[COORD_BITS-1:0], dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: two register settings per idle pattern
    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 21;
        rx_idle_pct = 85;
      end else if (ph < 4) begin
        tx_idle_pct = 85;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_random_regs(ph == 5);

      // last phase: a long miss streak drives the counter to its ceiling
      if (ph == 5)
        repeat (LONG_MISS_RUN) send_pos(regs_model.setpoint);

      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          // streak of misses, usually long enough to trip the lost flag
          run = $urandom_range(1, 10);
          repeat (run) send_pos(regs_model.setpoint);
          made += run;
        end else begin
          if (pick < 50) begin
            // tracking near the setpoint, small errors of either sign
            pos_i = regs_model.setpoint;
            pos_i = pos_i + int'($urandom_range(0, 16)) - 8;
            if (pos_i < 0)
              pos_i = 0;
            if (pos_i > 2047)
              pos_i = 2047;
          end else if (pick < 58) begin
            pos_i = $urandom_range(0, 1) ? 2047 : 0;
          end else begin
            pos_i = $urandom_range(0, 2047);
          end
          send_pos(pos_i[COORD_BITS-1:0]);
          made++;
        end
      end
    end

    settle();

    $display("covered %0d items (%0d directed rows), %0d register writes, %0d results checked",
             n_items, dir_rows.size(), n_writes, n_checked);
    $display("%0d drive updates, %0d results with target lost, %0d drives on a rail",
             n_updates, n_lost, n_sat);
    if (n_fail == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
